// ----- src/cau_pkg.sv -----
package cau_pkg;

    // Word format of every operand and result part.
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Derived widths of the internal datapath.
    localparam int SUM1_BITS   = WORD_BITS + 1;
    localparam int PROD_BITS   = 2 * WORD_BITS;
    localparam int MAG_BITS    = PROD_BITS + 1;
    localparam int NUM_BITS    = MAG_BITS + FRAC_BITS;
    localparam int HI_BITS     = NUM_BITS - WORD_BITS;
    localparam int SQ_REM_BITS = WORD_BITS + 2;
    localparam int STEPS       = WORD_BITS;

    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_SUB   = 3'd1,
        FN_MUL   = 3'd2,
        FN_DIV   = 3'd3,
        FN_CONJ  = 3'd4,
        FN_NEG   = 3'd5,
        FN_MAGSQ = 3'd6,
        FN_MAG   = 3'd7
    } t_func;

    typedef logic signed [WORD_BITS-1:0] t_word;

    typedef struct packed {
        t_func func;
        t_word a_re;
        t_word a_im;
        t_word b_re;
        t_word b_im;
    } t_in;

    typedef struct packed {
        t_word r_re;
        t_word r_im;
        logic  overflow;
        logic  div_zero;
    } t_out;

    // Everything one transaction carries along the row of step cells.
    typedef struct packed {
        logic                   valid;
        t_func                  func;
        logic                   neg_re;
        logic                   neg_im;
        logic [MAG_BITS-1:0]    pre_re;
        logic [MAG_BITS-1:0]    pre_im;
        logic                   ovf_re;
        logic                   ovf_im;
        logic                   dz;
        logic [PROD_BITS-1:0]   den;
        logic [PROD_BITS-1:0]   rem_re;
        logic [PROD_BITS-1:0]   rem_im;
        logic [WORD_BITS-1:0]   low_re;
        logic [WORD_BITS-1:0]   low_im;
        logic [WORD_BITS-1:0]   q_re;
        logic [WORD_BITS-1:0]   q_im;
        logic [PROD_BITS-1:0]   sq_x;
        logic [SQ_REM_BITS-1:0] sq_rem;
        logic [WORD_BITS-1:0]   sq_root;
    } t_cell;

endpackage

// ----- src/cau_front.sv -----
module cau_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  cau_pkg::t_in   i_data,
    output cau_pkg::t_cell o_cell
);

    // Stage 1: products and the short sums.
    logic                                   r_s1_valid;
    cau_pkg::t_func                         r_s1_func;
    logic signed [cau_pkg::PROD_BITS-1:0]   r_s1_p0, r_s1_p1, r_s1_p2, r_s1_p3;
    logic signed [cau_pkg::PROD_BITS-1:0]   r_s1_q0, r_s1_q1;
    logic signed [cau_pkg::SUM1_BITS-1:0]   r_s1_e_re, r_s1_e_im;
    logic signed [cau_pkg::PROD_BITS-1:0]   n_s1_p0, n_s1_p1, n_s1_p2, n_s1_p3;
    logic signed [cau_pkg::PROD_BITS-1:0]   n_s1_q0, n_s1_q1;
    logic signed [cau_pkg::SUM1_BITS-1:0]   n_s1_e_re, n_s1_e_im;
    cau_pkg::t_word                         sq_op_re, sq_op_im;

    // Stage 2: signed sums of products, the passed-on short sums and the sum of squares.
    logic                                   r_s2_valid;
    cau_pkg::t_func                         r_s2_func;
    logic signed [cau_pkg::MAG_BITS-1:0]    r_s2_re, r_s2_im;
    logic [cau_pkg::PROD_BITS-1:0]          r_s2_sq;
    logic signed [cau_pkg::MAG_BITS-1:0]    n_s2_re, n_s2_im;

    // Stage 3: sign and magnitude.
    logic                                   r_s3_valid;
    cau_pkg::t_func                         r_s3_func;
    logic                                   r_s3_neg_re, r_s3_neg_im;
    logic [cau_pkg::MAG_BITS-1:0]           r_s3_mag_re, r_s3_mag_im;
    logic [cau_pkg::PROD_BITS-1:0]          r_s3_sq;

    // Stage 4: head of the cell row.
    cau_pkg::t_cell                         r_cell, n_cell;
    logic [cau_pkg::NUM_BITS-1:0]           num_re, num_im;
    logic [cau_pkg::HI_BITS-1:0]            hi_re, hi_im;

    always_comb begin
        sq_op_re = (i_data.func == cau_pkg::FN_DIV) ? i_data.b_re : i_data.a_re;
        sq_op_im = (i_data.func == cau_pkg::FN_DIV) ? i_data.b_im : i_data.a_im;
        n_s1_p0  = i_data.a_re * i_data.b_re;
        n_s1_p1  = i_data.a_im * i_data.b_im;
        n_s1_p2  = i_data.a_re * i_data.b_im;
        n_s1_p3  = i_data.a_im * i_data.b_re;
        n_s1_q0  = sq_op_re * sq_op_re;
        n_s1_q1  = sq_op_im * sq_op_im;
        case (i_data.func)
            cau_pkg::FN_ADD: begin
                n_s1_e_re = cau_pkg::SUM1_BITS'(i_data.a_re) + cau_pkg::SUM1_BITS'(i_data.b_re);
                n_s1_e_im = cau_pkg::SUM1_BITS'(i_data.a_im) + cau_pkg::SUM1_BITS'(i_data.b_im);
            end
            cau_pkg::FN_SUB: begin
                n_s1_e_re = cau_pkg::SUM1_BITS'(i_data.a_re) - cau_pkg::SUM1_BITS'(i_data.b_re);
                n_s1_e_im = cau_pkg::SUM1_BITS'(i_data.a_im) - cau_pkg::SUM1_BITS'(i_data.b_im);
            end
            cau_pkg::FN_CONJ: begin
                n_s1_e_re = cau_pkg::SUM1_BITS'(i_data.a_re);
                n_s1_e_im = -cau_pkg::SUM1_BITS'(i_data.a_im);
            end
            cau_pkg::FN_NEG: begin
                n_s1_e_re = -cau_pkg::SUM1_BITS'(i_data.a_re);
                n_s1_e_im = -cau_pkg::SUM1_BITS'(i_data.a_im);
            end
            default: begin
                n_s1_e_re = '0;
                n_s1_e_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
            r_s1_func  <= i_data.func;
            r_s1_p0    <= n_s1_p0;
            r_s1_p1    <= n_s1_p1;
            r_s1_p2    <= n_s1_p2;
            r_s1_p3    <= n_s1_p3;
            r_s1_q0    <= n_s1_q0;
            r_s1_q1    <= n_s1_q1;
            r_s1_e_re  <= n_s1_e_re;
            r_s1_e_im  <= n_s1_e_im;
        end
    end

    always_comb begin
        case (r_s1_func)
            cau_pkg::FN_MUL: begin
                n_s2_re = cau_pkg::MAG_BITS'(r_s1_p0) - cau_pkg::MAG_BITS'(r_s1_p1);
                n_s2_im = cau_pkg::MAG_BITS'(r_s1_p2) + cau_pkg::MAG_BITS'(r_s1_p3);
            end
            cau_pkg::FN_DIV: begin
                n_s2_re = cau_pkg::MAG_BITS'(r_s1_p0) + cau_pkg::MAG_BITS'(r_s1_p1);
                n_s2_im = cau_pkg::MAG_BITS'(r_s1_p3) - cau_pkg::MAG_BITS'(r_s1_p2);
            end
            default: begin
                n_s2_re = cau_pkg::MAG_BITS'(r_s1_e_re);
                n_s2_im = cau_pkg::MAG_BITS'(r_s1_e_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s2_valid <= r_s1_valid;
            r_s2_func  <= r_s1_func;
            r_s2_re    <= n_s2_re;
            r_s2_im    <= n_s2_im;
            // Both squares are non-negative and their sum is at most 2^63,
            // which still fits the unsigned product width.
            r_s2_sq    <= r_s1_q0 + r_s1_q1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_adv) begin
            r_s3_valid  <= r_s2_valid;
            r_s3_func   <= r_s2_func;
            r_s3_neg_re <= r_s2_re[cau_pkg::MAG_BITS-1];
            r_s3_neg_im <= r_s2_im[cau_pkg::MAG_BITS-1];
            r_s3_mag_re <= r_s2_re[cau_pkg::MAG_BITS-1] ? -r_s2_re : r_s2_re;
            r_s3_mag_im <= r_s2_im[cau_pkg::MAG_BITS-1] ? -r_s2_im : r_s2_im;
            r_s3_sq     <= r_s2_sq;
        end
    end

    always_comb begin
        num_re = {r_s3_mag_re, {cau_pkg::FRAC_BITS{1'b0}}};
        num_im = {r_s3_mag_im, {cau_pkg::FRAC_BITS{1'b0}}};
        hi_re  = num_re[cau_pkg::NUM_BITS-1:cau_pkg::WORD_BITS];
        hi_im  = num_im[cau_pkg::NUM_BITS-1:cau_pkg::WORD_BITS];

        n_cell         = '0;
        n_cell.valid   = r_s3_valid;
        n_cell.func    = r_s3_func;
        n_cell.neg_re  = r_s3_neg_re;
        n_cell.neg_im  = r_s3_neg_im;
        n_cell.den     = r_s3_sq;
        n_cell.sq_x    = r_s3_sq;
        n_cell.dz      = (r_s3_func == cau_pkg::FN_DIV) && (r_s3_sq == '0);
        // A quotient of 2^WORD_BITS or more shows up as soon as the upper part
        // of the dividend reaches the divisor; otherwise that part is the
        // starting remainder of the division.
        n_cell.ovf_re  = cau_pkg::MAG_BITS'(hi_re) >= cau_pkg::MAG_BITS'(r_s3_sq);
        n_cell.ovf_im  = cau_pkg::MAG_BITS'(hi_im) >= cau_pkg::MAG_BITS'(r_s3_sq);
        n_cell.rem_re  = cau_pkg::PROD_BITS'(hi_re);
        n_cell.rem_im  = cau_pkg::PROD_BITS'(hi_im);
        n_cell.low_re  = num_re[cau_pkg::WORD_BITS-1:0];
        n_cell.low_im  = num_im[cau_pkg::WORD_BITS-1:0];
        case (r_s3_func)
            cau_pkg::FN_MUL: begin
                n_cell.pre_re = r_s3_mag_re >> cau_pkg::FRAC_BITS;
                n_cell.pre_im = r_s3_mag_im >> cau_pkg::FRAC_BITS;
            end
            cau_pkg::FN_MAGSQ: begin
                n_cell.neg_re = 1'b0;
                n_cell.neg_im = 1'b0;
                n_cell.pre_re = cau_pkg::MAG_BITS'(r_s3_sq >> cau_pkg::FRAC_BITS);
                n_cell.pre_im = '0;
            end
            default: begin
                n_cell.pre_re = r_s3_mag_re;
                n_cell.pre_im = r_s3_mag_im;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_adv) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ----- src/cau_cell.sv -----
module cau_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  cau_pkg::t_cell i_d,
    output cau_pkg::t_cell o_q
);

    cau_pkg::t_cell                     r_q, n_q;
    logic [cau_pkg::PROD_BITS:0]        den_x, t_re, t_im;
    logic [cau_pkg::SQ_REM_BITS+1:0]    s_rem, s_trial;
    logic                               bit_re, bit_im, bit_sq;

    // One restoring division step on each lane and one square root step.
    always_comb begin
        n_q     = i_d;
        den_x   = {1'b0, i_d.den};
        t_re    = {i_d.rem_re, i_d.low_re[cau_pkg::WORD_BITS-1]};
        t_im    = {i_d.rem_im, i_d.low_im[cau_pkg::WORD_BITS-1]};
        bit_re  = t_re >= den_x;
        bit_im  = t_im >= den_x;
        n_q.rem_re = bit_re ? cau_pkg::PROD_BITS'(t_re - den_x) : t_re[cau_pkg::PROD_BITS-1:0];
        n_q.rem_im = bit_im ? cau_pkg::PROD_BITS'(t_im - den_x) : t_im[cau_pkg::PROD_BITS-1:0];
        n_q.q_re   = {i_d.q_re[cau_pkg::WORD_BITS-2:0], bit_re};
        n_q.q_im   = {i_d.q_im[cau_pkg::WORD_BITS-2:0], bit_im};
        n_q.low_re = {i_d.low_re[cau_pkg::WORD_BITS-2:0], 1'b0};
        n_q.low_im = {i_d.low_im[cau_pkg::WORD_BITS-2:0], 1'b0};

        s_rem   = {i_d.sq_rem, i_d.sq_x[cau_pkg::PROD_BITS-1:cau_pkg::PROD_BITS-2]};
        s_trial = (cau_pkg::SQ_REM_BITS+2)'({i_d.sq_root, 2'b01});
        bit_sq  = s_rem >= s_trial;
        n_q.sq_rem  = bit_sq ? cau_pkg::SQ_REM_BITS'(s_rem - s_trial)
                             : cau_pkg::SQ_REM_BITS'(s_rem);
        n_q.sq_root = {i_d.sq_root[cau_pkg::WORD_BITS-2:0], bit_sq};
        n_q.sq_x    = {i_d.sq_x[cau_pkg::PROD_BITS-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ----- src/cau_back.sv -----
module cau_back (
    input  cau_pkg::t_cell i_c,
    output cau_pkg::t_out  o_res
);

    typedef struct packed {
        cau_pkg::t_word val;
        logic           ovf;
    } t_sat;

    t_sat sat_re, sat_im;

    // Clamps a sign and magnitude pair to the word range.
    function automatic t_sat sat_mag(input logic neg, input logic force_ovf,
                                     input logic [cau_pkg::MAG_BITS-1:0] m);
        t_sat                          s;
        logic [cau_pkg::MAG_BITS-1:0]  lim;
        logic [cau_pkg::WORD_BITS-1:0] low;
        lim = cau_pkg::MAG_BITS'(1) << (cau_pkg::WORD_BITS - 1);
        if (!neg) begin
            lim = lim - cau_pkg::MAG_BITS'(1);
        end
        low = m[cau_pkg::WORD_BITS-1:0];
        if (force_ovf || (m > lim)) begin
            s.ovf = 1'b1;
            s.val = neg ? {1'b1, {(cau_pkg::WORD_BITS-1){1'b0}}}
                        : {1'b0, {(cau_pkg::WORD_BITS-1){1'b1}}};
        end else begin
            s.ovf = 1'b0;
            s.val = neg ? cau_pkg::t_word'(-low) : cau_pkg::t_word'(low);
        end
        return s;
    endfunction

    always_comb begin
        o_res = '0;
        case (i_c.func)
            cau_pkg::FN_DIV: begin
                sat_re = sat_mag(i_c.neg_re, i_c.ovf_re, cau_pkg::MAG_BITS'(i_c.q_re));
                sat_im = sat_mag(i_c.neg_im, i_c.ovf_im, cau_pkg::MAG_BITS'(i_c.q_im));
            end
            cau_pkg::FN_MAG: begin
                sat_re = sat_mag(1'b0, 1'b0, cau_pkg::MAG_BITS'(i_c.sq_root));
                sat_im = sat_mag(1'b0, 1'b0, '0);
            end
            default: begin
                sat_re = sat_mag(i_c.neg_re, 1'b0, i_c.pre_re);
                sat_im = sat_mag(i_c.neg_im, 1'b0, i_c.pre_im);
            end
        endcase
        if (i_c.dz) begin
            o_res.div_zero = 1'b1;
        end else begin
            o_res.r_re     = sat_re.val;
            o_res.r_im     = sat_im.val;
            o_res.overflow = sat_re.ovf | sat_im.ovf;
        end
    end

endmodule

// ----- src/complex_arithmetic_unit.sv -----
// Complex arithmetic unit on signed Q16.16 operands.
// Input channel: i_valid, o_stall and i_data carry one transaction with an
// operation code and the two complex operands A and B. Output channel:
// o_valid, i_stall and o_data carry one result transaction with the real
// and imaginary parts, an overflow flag and a divide-by-zero flag.
// A transaction moves at a rising edge where valid is high and stall is low.
// Every input transaction gives exactly one result, in order. One
// transaction enters per cycle while o_stall is low. The pipeline is made
// of four front stages (products, sums, sign and magnitude, divider
// setup) and a row of 32 step cells, each doing one quotient bit of both
// divider lanes and one square root digit.
// Reset clears all valid bits, so the pipeline comes up empty and o_valid
// and o_stall are low. When the receiver stalls, the output register holds
// its transaction and one more finished result goes into a skid register;
// only then does o_stall rise and the whole pipeline freeze, and it resumes
// in the cycle after the skid register has been emptied.
module complex_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cau_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output cau_pkg::t_out o_data
);

    cau_pkg::t_cell chain [cau_pkg::STEPS+1];
    cau_pkg::t_out  res;
    cau_pkg::t_out  r_out_data, r_skid_data;
    logic           r_out_valid, r_skid_valid;
    logic           adv;
    logic           arrive;

    // The pipeline moves whenever the skid register is free.
    assign adv     = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign arrive  = adv && chain[cau_pkg::STEPS].valid;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_cell  (chain[0])
    );

    for (genvar g = 0; g < cau_pkg::STEPS; g++) begin : g_cell
        cau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_d     (chain[g]),
            .o_q     (chain[g+1])
        );
    end

    cau_back u_back (
        .i_c   (chain[cau_pkg::STEPS]),
        .o_res (res)
    );

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= arrive;
                r_out_data   <= res;
            end
        end else if (arrive) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule
